// ===== sv/mersenne_twister_generator_macros.svh =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator_macros
// assertion macros used by the generator rtl
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// same-cycle implication
`define MTG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtg assertion failed");

// next-cycle implication
`define MTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtg assertion failed");

`endif

// ===== sv/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// types and constants of the mersenne twister generator
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;
  localparam logic [WORD_W-1:0] SEED_MULT  = 32'd69069;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd4357;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    ST_SEED,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic seeding;
    logic first;
  } fb_ctrl_t;

endpackage

// ===== sv/mtg_cell.sv =====
// ----------------------------------------------------------------------------
// mtg_cell
// one word of the state table, shifts toward the head when enabled
// ----------------------------------------------------------------------------
module mtg_cell import mtg_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t d_i,
  output word_t q_o
);

  word_t word_q;
  word_t word_d;

  assign word_d = en_i ? d_i : word_q;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign q_o = word_q;

endmodule

// ===== sv/mtg_feedback.sv =====
// ----------------------------------------------------------------------------
// mtg_feedback
// word fed into the tail of the chain: seed, seed recurrence or twist,
// plus tempering of the twisted word
// ----------------------------------------------------------------------------
module mtg_feedback import mtg_pkg::*; (
  input  fb_ctrl_t ctrl_i,
  input  word_t    seed_i,
  input  word_t    head_i,
  input  word_t    next_i,
  input  word_t    tap_i,
  input  word_t    tail_i,
  output word_t    new_word_o,
  output word_t    tempered_o
);

  word_t y;
  word_t twisted;
  word_t seed_step;
  word_t t1;
  word_t t2;
  word_t t3;

  assign y         = (head_i & UPPER_MASK) | (next_i & LOWER_MASK);
  assign twisted   = tap_i ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
  assign seed_step = word_t'(tail_i * SEED_MULT);

  always_comb begin
    if (!ctrl_i.seeding) begin
      new_word_o = twisted;
    end else if (ctrl_i.first) begin
      new_word_o = seed_i;
    end else begin
      new_word_o = seed_step;
    end
  end

  assign t1         = twisted ^ (twisted >> 11);
  assign t2         = t1 ^ ((t1 << 7) & TEMPER_B);
  assign t3         = t2 ^ ((t2 << 15) & TEMPER_C);
  assign tempered_o = t3 ^ (t3 >> 18);

endmodule

// ===== sv/mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// mt19937 word generator built as a circular chain of word cells
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i/in_ready_o, reseed_i): reseed_i low asks for the
//   next tempered word, reseed_i high reloads the table from the seed register
//   and gives no result.
//   cfg channel (cfg_valid_i/cfg_ready_o, seed_value_i): writes the seed used
//   by the next reseed; always ready.
//   out channel (out_valid_o/out_ready_i, random_word_o): one result per word
//   request, held in an output register.
// word requests and reseeds:
//   a word request is answered in the cycle after it is accepted; requests can be
//   accepted every cycle as long as out_ready_i takes each result, since each one
//   shifts the chain by one cell and the new tail word is twisted on the fly.
//   a reseed fills one cell per cycle through the seed multiplier, and no item
//   is accepted until the whole table is filled.
// reset: the seed register returns to 4357 and the block seeds itself before
//   the first item is accepted.
// stall: while a result waits on out_ready_i, a new request is accepted only
//   in the cycle the waiting result is taken.
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_macros.svh"

module mersenne_twister_generator import mtg_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 624,
  parameter int unsigned TAP_OFFSET  = 397
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  reseed_i,
  input  logic  cfg_valid_i,
  output logic  cfg_ready_o,
  input  word_t seed_value_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output word_t random_word_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH - 1);

  state_e          state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  word_t           seed_q, seed_d;
  logic            out_valid_q, out_valid_d;
  word_t           word_q, word_d;

  logic     shift_en;
  logic     in_accept;
  logic     next_accept;
  fb_ctrl_t fb_ctrl;
  word_t    new_word;
  word_t    tempered;
  word_t    chain [TABLE_DEPTH];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign in_accept   = in_valid_i && in_ready_o;
  assign next_accept = in_accept && !reseed_i;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    shift_en = 1'b0;
    case (state_q)
      ST_SEED: begin
        shift_en = 1'b1;
        if (count_q == CNT_LAST) begin
          count_d = '0;
          state_d = ST_RUN;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      ST_RUN: begin
        if (in_accept) begin
          if (reseed_i) begin
            state_d = ST_SEED;
          end else begin
            shift_en = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_SEED;
        count_d = '0;
      end
    endcase
  end

  assign fb_ctrl.seeding = (state_q == ST_SEED);
  assign fb_ctrl.first   = (count_q == '0);

  assign seed_d      = (cfg_valid_i && cfg_ready_o) ? seed_value_i : seed_q;
  assign out_valid_d = next_accept ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign word_d      = next_accept ? tempered : word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED;
      count_q     <= '0;
      seed_q      <= SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  mtg_feedback u_feedback (
    .ctrl_i     (fb_ctrl),
    .seed_i     (seed_q),
    .head_i     (chain[0]),
    .next_i     (chain[1]),
    .tap_i      (chain[TAP_OFFSET]),
    .tail_i     (chain[TABLE_DEPTH-1]),
    .new_word_o (new_word),
    .tempered_o (tempered)
  );

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    if (j == TABLE_DEPTH - 1) begin : g_tail
      mtg_cell u_cell (
        .clk_i (clk_i),
        .en_i  (shift_en),
        .d_i   (new_word),
        .q_o   (chain[j])
      );
    end else begin : g_body
      mtg_cell u_cell (
        .clk_i (clk_i),
        .en_i  (shift_en),
        .d_i   (chain[j+1]),
        .q_o   (chain[j])
      );
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = word_q;

  `MTG_ASSERT_NEXT(a_reseed_blocks, clk_i, rst_ni, in_accept && reseed_i, !in_ready_o)
  `MTG_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, next_accept, out_valid_o)
  `MTG_ASSERT_NEXT(a_seed_runs, clk_i, rst_ni,
                   (state_q == ST_SEED) && (count_q != CNT_LAST), state_q == ST_SEED)
  `MTG_ASSERT_SAME(a_count_idle, clk_i, rst_ni, state_q == ST_RUN, count_q == '0)

endmodule

// ===== tb/mersenne_twister_checker.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_checker
// watches the item, seed and word channels of the mt19937 generator, keeps
// its own copy of the word table and seed, predicts every tempered word and
// compares each delivered word with the oldest prediction
// ----------------------------------------------------------------------------
module mersenne_twister_checker import mtg_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 624,
  parameter int unsigned TAP_OFFSET  = 397
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_ready_o,
  input  logic  reseed_i,
  input  logic  cfg_valid_i,
  input  logic  cfg_ready_o,
  input  word_t seed_value_i,
  input  logic  out_valid_o,
  input  logic  out_ready_i,
  input  word_t random_word_o,
  output int    error_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  word_t       mt_words [TABLE_DEPTH];
  int unsigned read_pos;
  word_t       seed_reg;
  word_t       expected_words [$];
  word_t       want;
  int          errors;

  function automatic void twist_words();
    word_t y;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      y = (mt_words[k] & UPPER_MASK) |
          (mt_words[(k + TABLE_DEPTH - 1) % TABLE_DEPTH] & LOWER_MASK);
      mt_words[k] = mt_words[(k + TABLE_DEPTH - TAP_OFFSET) % TABLE_DEPTH] ^
                    (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
    end
    read_pos = TABLE_DEPTH;
  endfunction

  function automatic void seed_words();
    mt_words[TABLE_DEPTH-1] = seed_reg;
    for (int i = TABLE_DEPTH - 2; i >= 0; i--) begin
      mt_words[i] = mt_words[i+1] * SEED_MULT;
    end
    twist_words();
  endfunction

  function automatic word_t temper_word(input word_t v);
    word_t t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_reg = SEED_RESET;
      seed_words();
      expected_words.delete();
      errors = 0;
      error_count_o <= 0;
      pending_o <= 0;
    end else begin
      // word from an earlier item leaves before this edge's item is counted
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("random_word: no item waiting, actual %h", random_word_o);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (random_word_o !== want) begin
            $error("random_word: expected %h, actual %h", want, random_word_o);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        seed_reg = seed_value_i;
      end
      if (in_valid_i && in_ready_o) begin
        if (reseed_i) begin
          seed_words();
        end else begin
          if (read_pos == 0) begin
            twist_words();
          end
          read_pos--;
          expected_words.push_back(temper_word(mt_words[read_pos]));
        end
      end
      error_count_o <= errors;
      pending_o <= expected_words.size();
    end
  end

endmodule

// ===== tb/tb_mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// tb_mersenne_twister_generator
// drives word requests and reseeds with random gaps and output stalls,
// changes the seed between phases, runs past table exhaustion, and reports
// the verdict from the checker's error and pending counts
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator import mtg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH  = 624;
  localparam int unsigned TAP    = 397;
  localparam int unsigned SETTLE = DEPTH + 32;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  logic  reseed_i;
  logic  cfg_valid_i;
  logic  cfg_ready_o;
  word_t seed_value_i;
  logic  out_valid_o;
  logic  out_ready_i;
  word_t random_word_o;

  int    check_errors;
  int    words_pending;
  bit    calm_phase;
  int    stall;
  word_t short_seeds [6];

  mersenne_twister_generator #(
    .TABLE_DEPTH(DEPTH),
    .TAP_OFFSET (TAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .reseed_i     (reseed_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .seed_value_i (seed_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .random_word_o(random_word_o)
  );

  mersenne_twister_checker #(
    .TABLE_DEPTH(DEPTH),
    .TAP_OFFSET (TAP)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .reseed_i     (reseed_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .seed_value_i (seed_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .random_word_o(random_word_o),
    .error_count_o(check_errors),
    .pending_o    (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // word receiver with random stalls
  initial begin
    forever begin
      stall = calm_phase ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_item(input logic reseed);
    int gap;
    gap = calm_phase ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    reseed_i <= reseed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    // a reseed gives no word but keeps the block busy
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_seed(input word_t seed);
    cfg_valid_i <= 1'b1;
    seed_value_i <= seed;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input word_t seed, input int count, input int reseed_odds,
                           input bit fresh, input bit calm);
    int n;
    wait_idle();
    write_seed(seed);
    calm_phase = calm;
    if (fresh) begin
      send_item(1'b1);
    end
    for (n = 0; n < count; n++) begin
      send_item(reseed_odds != 0 && $urandom_range(0, reseed_odds - 1) == 0);
    end
  endtask

  initial begin
    calm_phase = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    reseed_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    seed_value_i <= '0;
    short_seeds[0] = SEED_RESET;
    short_seeds[1] = 32'h0000_0001;
    short_seeds[2] = 32'h8000_0000;
    short_seeds[3] = $urandom;
    short_seeds[4] = $urandom;
    short_seeds[5] = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // words from the self-seeded table, then reseeds with the reset seed
    repeat (3) send_item(1'b0);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    run_phase(32'h0000_0000, 4, 0, 1'b1, 1'b0);
    run_phase(32'hFFFF_FFFF, 4, 0, 1'b1, 1'b0);

    // long runs past table exhaustion
    run_phase($urandom, 700, 0, 1'b1, 1'b0);
    run_phase($urandom, 700, 0, 1'b1, 1'b1);

    // short phases with scattered reseeds, some without a fresh reseed
    for (int p = 0; p < 6; p++) begin
      run_phase(short_seeds[p], 35, 8, $urandom_range(0, 3) != 0, p == 2);
    end

    wait_idle();
    if (check_errors == 0 && words_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
